// ===== hdl/lmfd_pkg.sv =====
// ----------------------------------------------------------------------------
// lmfd_pkg
// Shared types and constants of the length-marker frame deframer.
// ----------------------------------------------------------------------------
package lmfd_pkg;

  // Default number of bytes in the big-endian length field (1 to 4).
  localparam int LEN_BYTES_DEF = 4;

  localparam logic [7:0]  MARKER_BYTE  = 8'hFF;
  localparam logic [15:0] TRAILER_WORD = 16'hFFFF;

  // Status carried by the byte that closes a header attempt or a frame.
  typedef enum logic [1:0] {
    ST_ONGOING     = 2'd0,
    ST_GOOD        = 2'd1,
    ST_BAD_MARKER  = 2'd2,
    ST_BAD_TRAILER = 2'd3
  } status_t;

  // One result: the echoed byte and its framing flags.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       in_frame;
    logic       frame_end;
    status_t    frame_status;
  } result_t;

endpackage

// ===== hdl/lmfd_core.sv =====
// ----------------------------------------------------------------------------
// lmfd_core
// Framing state machine: header assembly, marker check, payload countdown
// and trailer check, with the flags for the current byte.
// ----------------------------------------------------------------------------
module lmfd_core
  import lmfd_pkg::*;
#(
  parameter int LEN_BYTES = LEN_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       take,
  input  logic [7:0] data_byte,
  output result_t    result
);

  localparam int LenW = 8 * LEN_BYTES;
  localparam int HcW  = $clog2(LEN_BYTES + 1);
  localparam logic [HcW-1:0] HcLast = HcW'(LEN_BYTES);

  logic            in_payload, in_payload_next;
  logic [HcW-1:0]  header_count, header_count_next;
  logic [LenW-1:0] length_shift, length_shift_next;
  logic [LenW-1:0] payload_left, payload_left_next;
  logic [15:0]     last_two_bytes, last_two_bytes_next;
  logic [LenW+7:0] length_cat;
  logic [15:0]     trailer_cat;

  assign length_cat  = {length_shift, data_byte};
  assign trailer_cat = {last_two_bytes[7:0], data_byte};

  always_comb begin
    in_payload_next     = in_payload;
    header_count_next   = header_count;
    length_shift_next   = length_shift;
    payload_left_next   = payload_left;
    last_two_bytes_next = last_two_bytes;
    result.out_byte     = data_byte;
    result.in_frame     = 1'b1;
    result.frame_end    = 1'b0;
    result.frame_status = ST_ONGOING;

    if (in_payload) begin
      last_two_bytes_next = trailer_cat;
      payload_left_next   = payload_left - LenW'(1);
      if (payload_left == LenW'(1)) begin
        result.frame_end    = 1'b1;
        result.frame_status = (trailer_cat == TRAILER_WORD) ? ST_GOOD : ST_BAD_TRAILER;
        in_payload_next     = 1'b0;
        header_count_next   = '0;
        length_shift_next   = '0;
        payload_left_next   = '0;
        last_two_bytes_next = '0;
      end
    end else if (header_count < HcLast) begin
      length_shift_next = length_cat[LenW-1:0];
      header_count_next = header_count + HcW'(1);
    end else begin
      // Marker position: restart unless the marker is good and the length usable.
      header_count_next = '0;
      length_shift_next = '0;
      if (data_byte != MARKER_BYTE) begin
        result.in_frame     = 1'b0;
        result.frame_end    = 1'b1;
        result.frame_status = ST_BAD_MARKER;
      end else if (length_shift < LenW'(2)) begin
        result.frame_end    = 1'b1;
        result.frame_status = ST_BAD_TRAILER;
      end else begin
        in_payload_next     = 1'b1;
        payload_left_next   = length_shift;
        last_two_bytes_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_payload     <= 1'b0;
      header_count   <= '0;
      length_shift   <= '0;
      payload_left   <= '0;
      last_two_bytes <= '0;
    end else if (take) begin
      in_payload     <= in_payload_next;
      header_count   <= header_count_next;
      length_shift   <= length_shift_next;
      payload_left   <= payload_left_next;
      last_two_bytes <= last_two_bytes_next;
    end
  end

`ifndef SYNTHESIS
  a_payload_nonzero : assert property (@(posedge clk) disable iff (rst)
    in_payload |-> payload_left != '0)
    else $error("payload count is zero inside a payload");

  a_payload_no_header : assert property (@(posedge clk) disable iff (rst)
    in_payload |-> header_count == '0)
    else $error("header count not cleared inside a payload");

  a_enter_payload : assert property (@(posedge clk) disable iff (rst)
    (take && !in_payload && header_count == HcLast && data_byte == MARKER_BYTE
     && length_shift >= LenW'(2)) |=> (in_payload && payload_left == $past(length_shift)))
    else $error("payload entry did not load the length");
`endif

endmodule

// ===== hdl/length_marker_frame_deframer_unit.sv =====
// ----------------------------------------------------------------------------
// length_marker_frame_deframer_unit
// Byte-stream deframer for frames of a big-endian length, a 0xFF marker and
// a payload that must end in 0xFFFF; each byte is echoed with framing flags.
//
//   channel  direction  handshake             payload
//   in       input      in_valid / in_ready   data_byte
//   out      output     out_valid / out_ready out_byte, in_frame,
//                                             frame_end, frame_status
//
// Each request's byte is decoded against the framing state in the cycle
// it is accepted and the result lands in the output register at that edge,
// so one request per cycle is sustained while the out side does not stall.
// The output register is the only stage; a new request is accepted while
// the held result is being taken in the same cycle.
// A stall on the out side holds the result and deasserts in_ready.
// Reset (rst, synchronous) restarts the header search and empties the output.
// ----------------------------------------------------------------------------
module length_marker_frame_deframer_unit
  import lmfd_pkg::*;
#(
  parameter int LEN_BYTES = LEN_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] data_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       in_frame,
  output logic       frame_end,
  output logic [1:0] frame_status
);

  // A request is taken whenever the output register is empty or is being
  // drained in this same cycle.
  logic    take;
  result_t result;
  result_t out_reg;

  assign in_ready = !out_valid || out_ready;
  assign take     = in_valid && in_ready;

  // The core advances its framing state only on an accepted request.
  lmfd_core #(
    .LEN_BYTES (LEN_BYTES)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .data_byte (data_byte),
    .result    (result)
  );

  // Result register: the valid flag is control state, the payload is not reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_reg <= result;
    end
  end

  assign out_byte     = out_reg.out_byte;
  assign in_frame     = out_reg.in_frame;
  assign frame_end    = out_reg.frame_end;
  assign frame_status = out_reg.frame_status;

`ifndef SYNTHESIS
  a_status_only_at_end : assert property (@(posedge clk) disable iff (rst)
    (out_valid && !frame_end) |-> frame_status == ST_ONGOING)
    else $error("status reported on a byte that does not close a frame");

  a_bad_marker_outside : assert property (@(posedge clk) disable iff (rst)
    (out_valid && frame_status == ST_BAD_MARKER) |-> !in_frame)
    else $error("bad marker byte flagged as in frame");

  a_take_loads_output : assert property (@(posedge clk) disable iff (rst)
    take |=> (out_valid && out_byte == $past(data_byte)))
    else $error("accepted request did not reach the output register");
`endif

endmodule
